// ----- hw/rtl/mabis_pkg.sv -----
// ----------------------------------------------------------------------------
// mabis_pkg
// Shared types, constants and helpers of the multi-axis brush index selector.
// ----------------------------------------------------------------------------
package mabis_pkg;

  localparam int MAX_AXES   = 4;
  localparam int AXIS_W     = $clog2(MAX_AXES);
  localparam int NDIM_W     = 3;
  localparam int CNT_W      = 13;
  localparam int IDX_W      = 12;
  localparam int MODES_W    = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int SUM_W      = 26;
  localparam int MUL_A_W    = 34;
  localparam int MUL_B_W    = 14;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int REM_STEPS  = 13;
  localparam int REM_CNT_W  = 4;

  localparam logic [CNT_W-1:0] MAX_BRUSHES  = 13'd4096;
  localparam logic [CNT_W-1:0] RANK_CAP     = 13'd4096;
  localparam logic [31:0]      LFSR_SEED    = 32'hACE1ACE1;
  localparam logic [31:0]      LFSR_TAPS    = 32'h80200003;
  localparam logic [17:0]      ANGLE_OFFSET = 18'd81920;

  typedef enum logic [2:0] {
    MODE_CONST  = 3'd0,
    MODE_INCR   = 3'd1,
    MODE_ANGLE  = 3'd2,
    MODE_VEL    = 3'd3,
    MODE_RANDOM = 3'd4,
    MODE_PRES   = 3'd5,
    MODE_XTILT  = 3'd6,
    MODE_YTILT  = 3'd7
  } mabis_mode_t;

  typedef enum logic [2:0] {
    CFG_DIMS    = 3'd0,
    CFG_BRUSHES = 3'd1,
    CFG_MODES   = 3'd2,
    CFG_RANK0   = 3'd3,
    CFG_RANK1   = 3'd4,
    CFG_RANK2   = 3'd5,
    CFG_RANK3   = 3'd6
  } mabis_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STR_MUL,
    ST_STR_ACC,
    ST_AX_MUL,
    ST_REM_WAIT,
    ST_AX_EVAL,
    ST_SUM_MUL,
    ST_SUM_ACC,
    ST_OUT
  } mabis_state_t;

  typedef struct packed {
    logic load_in;
    logic str_mul;
    logic str_acc;
    logic ax_mul;
    logic ax_eval;
    logic sum_mul;
    logic sum_acc;
    logic out_load;
  } mabis_cmd_t;

  typedef struct packed {
    logic single;
    logic dims_zero;
    logic axis_zero;
    logic axis_last;
    logic mode_incr;
    logic rem_done;
  } mabis_status_t;

  // Zero counts as one and large counts saturate at the cap.
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] v,
                                                 input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (v > cap) begin
      r = cap;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/mabis_rem.sv -----
// ----------------------------------------------------------------------------
// mabis_rem
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mabis_rem (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [mabis_pkg::CNT_W-1:0] dividend,
  input  logic [mabis_pkg::CNT_W-1:0] divisor,
  output logic                        done,
  output logic [mabis_pkg::CNT_W-1:0] remainder
);
  import mabis_pkg::*;

  logic                 busy;
  logic [REM_CNT_W-1:0] count;
  logic [CNT_W-1:0]     quo;
  logic [CNT_W:0]       trial;
  logic [CNT_W:0]       diff;

  assign trial = {remainder, quo[CNT_W-1]};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= REM_CNT_W'(REM_STEPS);
      end else if (busy) begin
        count <= count - REM_CNT_W'(1);
        if (count == REM_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo       <= dividend;
      remainder <= '0;
    end else if (busy) begin
      quo <= {quo[CNT_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        remainder <= diff[CNT_W-1:0];
      end else begin
        remainder <= trial[CNT_W-1:0];
      end
    end
  end

endmodule

// ----- hw/rtl/mabis_dp.sv -----
// ----------------------------------------------------------------------------
// mabis_dp
// Datapath: configuration registers, axis state, LFSR, the shared multiplier,
// index evaluation and clamping, stride and sum accumulation, result register.
// ----------------------------------------------------------------------------
module mabis_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mabis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mabis_pkg::CFG_DATA_W-1:0] cfg_data,
  input  mabis_pkg::mabis_cmd_t            cmd,
  output mabis_pkg::mabis_status_t         status,
  input  logic [15:0]                      stroke_direction,
  input  logic [16:0]                      stroke_velocity,
  input  logic [16:0]                      pen_pressure,
  input  logic signed [17:0]               tilt_x,
  input  logic signed [17:0]               tilt_y,
  output logic [mabis_pkg::IDX_W-1:0]      brush_index,
  output logic                             wants_null_motion
);
  import mabis_pkg::*;

  logic [NDIM_W-1:0]  dims_reg;
  logic [CNT_W-1:0]   brushes_reg;
  logic [MODES_W-1:0] modes_reg;
  logic [CNT_W-1:0]   rank_reg [MAX_AXES];

  logic [IDX_W-1:0]   axis_index [MAX_AXES];
  logic [CNT_W-1:0]   axis_stride [MAX_AXES];
  logic [31:0]        random_lfsr;

  logic [15:0]        dir_q;
  logic [16:0]        vel_q;
  logic [16:0]        pres_q;
  logic signed [17:0] tx_q;
  logic signed [17:0] ty_q;

  logic [AXIS_W-1:0]  axis;
  logic [CNT_W-1:0]   prod_acc;
  logic [SUM_W-1:0]   sum;
  logic               null_flag;
  logic signed [PROD_W-1:0] product;

  logic [NDIM_W-1:0]  n_eff;
  logic [NDIM_W-1:0]  n_m1;
  logic [CNT_W-1:0]   nb;
  logic [CNT_W-1:0]   nb_m1;
  logic [CNT_W-1:0]   r;
  logic [CNT_W-1:0]   r_m1;
  mabis_mode_t        mode_arr [MAX_AXES];
  mabis_mode_t        m;
  logic [31:0]        lfsr_next;
  logic [17:0]        ang;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  rnd16;
  logic signed [PROD_W-1:0]  rnd17;
  logic signed [PROD_W-1:0]  r_s;
  logic signed [PROD_W-1:0]  r_m1_s;
  logic signed [PROD_W-1:0]  cand;
  logic [IDX_W-1:0]          clamp_idx;

  logic                 rem_done;
  logic [CNT_W-1:0]     rem_value;
  logic [CNT_W-1:0]     rem_dividend;

  assign n_eff = (dims_reg > NDIM_W'(MAX_AXES)) ? NDIM_W'(MAX_AXES) : dims_reg;
  assign n_m1  = n_eff - NDIM_W'(1);
  assign nb    = eff_count(brushes_reg, MAX_BRUSHES);
  assign nb_m1 = nb - CNT_W'(1);
  assign r     = eff_count(rank_reg[axis], RANK_CAP);
  assign r_m1  = r - CNT_W'(1);

  always_comb begin
    for (int k = 0; k < MAX_AXES; k++) begin
      mode_arr[k] = mabis_mode_t'(modes_reg[3*k +: 3]);
    end
  end
  assign m = mode_arr[axis];

  assign lfsr_next = (random_lfsr >> 1) ^ (random_lfsr[0] ? LFSR_TAPS : 32'd0);
  assign ang       = ANGLE_OFFSET - {2'b0, dir_q};
  assign rem_dividend = {1'b0, axis_index[axis]} + CNT_W'(1);

  mabis_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.ax_mul && (m == MODE_INCR)),
    .dividend  (rem_dividend),
    .divisor   (r),
    .done      (rem_done),
    .remainder (rem_value)
  );

  always_comb begin
    status.single    = (nb == CNT_W'(1));
    status.dims_zero = (n_eff == '0);
    status.axis_zero = (axis == '0);
    status.axis_last = ({1'b0, axis} == n_m1);
    status.mode_incr = (m == MODE_INCR);
    status.rem_done  = rem_done;
  end

  always_comb begin
    mul_a = '0;
    mul_b = $signed({1'b0, r});
    if (cmd.str_mul) begin
      mul_a = $signed({{(MUL_A_W-CNT_W){1'b0}}, prod_acc});
    end else if (cmd.sum_mul) begin
      mul_a = $signed({{(MUL_A_W-CNT_W){1'b0}}, axis_stride[axis]});
      mul_b = $signed({{(MUL_B_W-IDX_W){1'b0}}, axis_index[axis]});
    end else begin
      case (m)
        MODE_ANGLE:  mul_a = $signed({{(MUL_A_W-18){1'b0}}, ang});
        MODE_VEL:    mul_a = $signed({{(MUL_A_W-17){1'b0}}, vel_q});
        MODE_RANDOM: mul_a = $signed({{(MUL_A_W-32){1'b0}}, lfsr_next});
        MODE_PRES: begin
          mul_a = $signed({{(MUL_A_W-17){1'b0}}, pres_q});
          mul_b = $signed({1'b0, r_m1});
        end
        MODE_XTILT:  mul_a = {{(MUL_A_W-18){tx_q[17]}}, tx_q};
        MODE_YTILT:  mul_a = {{(MUL_A_W-18){ty_q[17]}}, ty_q};
        default:     mul_a = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    product <= mul_a * mul_b;
  end

  assign rnd16  = (product + PROD_W'(32768)) >>> 16;
  assign rnd17  = (product + PROD_W'(65536)) >>> 17;
  assign r_s    = $signed({{(PROD_W-CNT_W){1'b0}}, r});
  assign r_m1_s = $signed({{(PROD_W-CNT_W){1'b0}}, r_m1});

  always_comb begin
    case (m)
      MODE_INCR:   cand = $signed({{(PROD_W-CNT_W){1'b0}}, rem_value});
      MODE_ANGLE:  cand = (rnd16 >= r_s) ? (rnd16 - r_s) : rnd16;
      MODE_VEL:    cand = rnd16;
      MODE_RANDOM: cand = product >>> 32;
      MODE_PRES:   cand = rnd16;
      MODE_XTILT:  cand = rnd17 + (r_s >>> 1);
      MODE_YTILT:  cand = rnd17 + (r_s >>> 1);
      default:     cand = $signed({{(PROD_W-IDX_W){1'b0}}, axis_index[axis]});
    endcase
    if (cand < 0) begin
      clamp_idx = '0;
    end else if (cand > r_m1_s) begin
      clamp_idx = r_m1[IDX_W-1:0];
    end else begin
      clamp_idx = cand[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dims_reg    <= NDIM_W'(1);
      brushes_reg <= CNT_W'(1);
      modes_reg   <= MODES_W'(MODE_INCR);
      for (int k = 0; k < MAX_AXES; k++) begin
        rank_reg[k]   <= CNT_W'(1);
        axis_index[k] <= '0;
      end
      random_lfsr <= LFSR_SEED;
      axis        <= '0;
      null_flag   <= 1'b1;
    end else begin
      if (cfg_we) begin
        unique case (mabis_cfg_t'(cfg_index))
          CFG_DIMS:    dims_reg    <= cfg_data[NDIM_W-1:0];
          CFG_BRUSHES: brushes_reg <= cfg_data[CNT_W-1:0];
          CFG_MODES:   modes_reg   <= cfg_data[MODES_W-1:0];
          CFG_RANK0:   rank_reg[0] <= cfg_data[CNT_W-1:0];
          CFG_RANK1:   rank_reg[1] <= cfg_data[CNT_W-1:0];
          CFG_RANK2:   rank_reg[2] <= cfg_data[CNT_W-1:0];
          CFG_RANK3:   rank_reg[3] <= cfg_data[CNT_W-1:0];
          default:     ;
        endcase
      end
      if (cmd.ax_mul && (m == MODE_RANDOM)) begin
        random_lfsr <= lfsr_next;
      end
      if (cmd.ax_eval) begin
        axis_index[axis] <= clamp_idx;
        if (m == MODE_ANGLE) begin
          null_flag <= 1'b0;
        end
      end
      if (cmd.load_in) begin
        axis      <= n_m1[AXIS_W-1:0];
        null_flag <= 1'b1;
      end else if (cmd.str_acc) begin
        if (axis != '0) begin
          axis <= axis - AXIS_W'(1);
        end
      end else if (cmd.sum_acc) begin
        axis <= axis + AXIS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      dir_q    <= stroke_direction;
      vel_q    <= stroke_velocity;
      pres_q   <= pen_pressure;
      tx_q     <= tilt_x;
      ty_q     <= tilt_y;
      prod_acc <= CNT_W'(1);
      sum      <= '0;
    end
    if (cmd.str_acc) begin
      axis_stride[axis] <= prod_acc;
      if (product > $signed({{(PROD_W-CNT_W){1'b0}}, MAX_BRUSHES})) begin
        prod_acc <= MAX_BRUSHES;
      end else begin
        prod_acc <= product[CNT_W-1:0];
      end
    end
    if (cmd.sum_acc) begin
      sum <= sum + product[SUM_W-1:0];
    end
    if (cmd.out_load) begin
      if (status.single) begin
        brush_index <= '0;
      end else if (sum > SUM_W'(nb_m1)) begin
        brush_index <= nb_m1[IDX_W-1:0];
      end else begin
        brush_index <= sum[IDX_W-1:0];
      end
      wants_null_motion <= status.single | null_flag;
    end
  end

endmodule

// ----- hw/rtl/mabis_ctrl.sv -----
// ----------------------------------------------------------------------------
// mabis_ctrl
// Controller: sequences the stride pass, the per-axis evaluation and the sum,
// and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module mabis_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  logic                     out_ready,
  output mabis_pkg::mabis_cmd_t    cmd,
  input  mabis_pkg::mabis_status_t status
);
  import mabis_pkg::*;

  mabis_state_t state;
  mabis_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          if (status.single || status.dims_zero) begin
            state_next = ST_OUT;
          end else begin
            state_next = ST_STR_MUL;
          end
        end
      end
      ST_STR_MUL: begin
        cmd.str_mul = 1'b1;
        state_next  = ST_STR_ACC;
      end
      ST_STR_ACC: begin
        cmd.str_acc = 1'b1;
        state_next  = status.axis_zero ? ST_AX_MUL : ST_STR_MUL;
      end
      ST_AX_MUL: begin
        cmd.ax_mul = 1'b1;
        state_next = status.mode_incr ? ST_REM_WAIT : ST_AX_EVAL;
      end
      ST_REM_WAIT: begin
        if (status.rem_done) begin
          state_next = ST_AX_EVAL;
        end
      end
      ST_AX_EVAL: begin
        cmd.ax_eval = 1'b1;
        state_next  = ST_SUM_MUL;
      end
      ST_SUM_MUL: begin
        cmd.sum_mul = 1'b1;
        state_next  = ST_SUM_ACC;
      end
      ST_SUM_ACC: begin
        cmd.sum_acc = 1'b1;
        state_next  = status.axis_last ? ST_OUT : ST_AX_MUL;
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register loaded while a result was still pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after a transfer");

  a_rem_wait_incr: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REM_WAIT) |-> status.mode_incr)
    else $error("waiting on the remainder unit for a non-incremental axis");

  a_out_after_load: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("result loaded but not presented");

endmodule

// ----- hw/rtl/multi_axis_brush_index_select.sv -----
// ----------------------------------------------------------------------------
// multi_axis_brush_index_select
// Picks a cell of a multi-axis brush table from one stylus event.
// ----------------------------------------------------------------------------
// From input transfer to result the controller runs the stride pass over the n
// axes in use, then for each axis a multiply, an evaluation and a sum step,
// waiting on the one-bit-per-cycle remainder unit for each incremental axis.
// A single brush or no axes in use skips straight from input transfer to output.
// One event at a time; the next event is taken the cycle after the result loads.
// Synchronous reset restores the register defaults, the axis indices and the seed.
module multi_axis_brush_index_select (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mabis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mabis_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [15:0]                      stroke_direction,
  input  logic [16:0]                      stroke_velocity,
  input  logic [16:0]                      pen_pressure,
  input  logic signed [17:0]               tilt_x,
  input  logic signed [17:0]               tilt_y,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [11:0]                      brush_index,
  output logic                             wants_null_motion
);
  import mabis_pkg::*;

  mabis_cmd_t    cmd;
  mabis_status_t status;

  assign cfg_ready = 1'b1;

  mabis_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  mabis_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .cmd               (cmd),
    .status            (status),
    .stroke_direction  (stroke_direction),
    .stroke_velocity   (stroke_velocity),
    .pen_pressure      (pen_pressure),
    .tilt_x            (tilt_x),
    .tilt_y            (tilt_y),
    .brush_index       (brush_index),
    .wants_null_motion (wants_null_motion)
  );

endmodule

// ----- dv/multi_axis_brush_index_select_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_axis_brush_index_select_test
// Self-checking bench for the multi-axis brush index selector. A short
// directed set covers each axis mode, field extremes and the corner cases of
// the registers. Random configurations with random stylus events follow. A
// predictor tracks the axis indices, strides and random generator, and each
// result transfer is checked against the oldest predicted pick. Both sides
// idle at random, and the receiver once holds off long enough to stall input.
// ----------------------------------------------------------------------------
module multi_axis_brush_index_select_test;
  import mabis_pkg::*;

  typedef struct {
    logic [15:0]        direction;
    logic [16:0]        velocity;
    logic [16:0]        pressure;
    logic signed [17:0] tilt_x;
    logic signed [17:0] tilt_y;
  } stroke_t;

  typedef struct {
    logic [11:0] brush_index;
    logic        null_motion;
  } pick_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [15:0]           stroke_direction;
  logic [16:0]           stroke_velocity;
  logic [16:0]           pen_pressure;
  logic signed [17:0]    tilt_x;
  logic signed [17:0]    tilt_y;
  logic                  out_valid;
  logic                  out_ready;
  logic [11:0]           brush_index;
  logic                  wants_null_motion;

  stroke_t     pending_events[$];
  pick_t       expected_picks[$];
  stroke_t     offered_event;
  pick_t       oldest_pick;
  int          queued_total = 0;
  int          accepted_total = 0;
  int          mismatches = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  logic        steady = 1'b0;
  logic        hold_request = 1'b0;
  logic        hold_off = 1'b0;

  logic [2:0]  cur_dims;
  logic [12:0] cur_brushes;
  logic [11:0] cur_modes;
  logic [12:0] cur_rank[MAX_AXES];
  logic [11:0] idx_state[MAX_AXES];
  logic [12:0] stride_state[MAX_AXES];
  logic [31:0] lfsr_state;

  multi_axis_brush_index_select u_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .stroke_direction  (stroke_direction),
    .stroke_velocity   (stroke_velocity),
    .pen_pressure      (pen_pressure),
    .tilt_x            (tilt_x),
    .tilt_y            (tilt_y),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .brush_index       (brush_index),
    .wants_null_motion (wants_null_motion)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic longint clip_count(input logic [12:0] v, input logic [12:0] cap);
    longint c;
    c = longint'(v);
    if (v == '0) begin
      c = 1;
    end else if (v > cap) begin
      c = longint'(cap);
    end
    return c;
  endfunction

  function automatic pick_t predict_pick(input stroke_t ev);
    pick_t       pick;
    longint      r;
    longint      ix;
    longint      sum;
    longint      t;
    longint      nb;
    int          n;
    mabis_mode_t mode;
    logic        lsb;
    pick.brush_index = '0;
    pick.null_motion = 1'b1;
    nb = clip_count(cur_brushes, MAX_BRUSHES);
    if (nb == 1) begin
      return pick;
    end
    n = (int'(cur_dims) > MAX_AXES) ? MAX_AXES : int'(cur_dims);
    sum = 0;
    for (int i = 0; i < n; i++) begin
      r = clip_count(cur_rank[i], RANK_CAP);
      mode = mabis_mode_t'(cur_modes[3*i +: 3]);
      case (mode)
        MODE_INCR: begin
          t = longint'(idx_state[i]);
          ix = (t + 1) % r;
        end
        MODE_ANGLE: begin
          pick.null_motion = 1'b0;
          t = longint'(ANGLE_OFFSET) - longint'(ev.direction);
          ix = ((t * r + 32768) >>> 16) % r;
        end
        MODE_VEL: begin
          t = longint'(ev.velocity);
          ix = (t * r + 32768) >>> 16;
        end
        MODE_RANDOM: begin
          lsb = lfsr_state[0];
          lfsr_state = lfsr_state >> 1;
          if (lsb) begin
            lfsr_state = lfsr_state ^ LFSR_TAPS;
          end
          t = longint'(lfsr_state);
          ix = (t * r) >>> 32;
        end
        MODE_PRES: begin
          t = longint'(ev.pressure);
          ix = (t * (r - 1) + 32768) >>> 16;
        end
        MODE_XTILT: begin
          t = longint'(ev.tilt_x);
          ix = ((t * r + 65536) >>> 17) + r / 2;
        end
        MODE_YTILT: begin
          t = longint'(ev.tilt_y);
          ix = ((t * r + 65536) >>> 17) + r / 2;
        end
        default: begin
          ix = longint'(idx_state[i]);
        end
      endcase
      if (ix < 0) begin
        ix = 0;
      end
      if (ix > r - 1) begin
        ix = r - 1;
      end
      idx_state[i] = ix[11:0];
      t = longint'(stride_state[i]);
      sum = sum + t * ix;
    end
    if (sum > nb - 1) begin
      sum = nb - 1;
    end
    pick.brush_index = sum[11:0];
    return pick;
  endfunction

  function automatic stroke_t make_event(input int dir, input int vel, input int pres,
                                         input int tx, input int ty);
    stroke_t ev;
    ev.direction = 16'(dir);
    ev.velocity  = 17'(vel);
    ev.pressure  = 17'(pres);
    ev.tilt_x    = 18'(tx);
    ev.tilt_y    = 18'(ty);
    return ev;
  endfunction

  function automatic stroke_t random_event();
    stroke_t ev;
    ev.direction = 16'($urandom);
    if ($urandom_range(0, 7) == 0) begin
      ev.velocity = 17'($urandom);
      ev.pressure = 17'($urandom);
      ev.tilt_x   = 18'($urandom);
      ev.tilt_y   = 18'($urandom);
    end else begin
      ev.velocity = 17'($urandom_range(0, 65536));
      ev.pressure = 17'($urandom_range(0, 65536));
      ev.tilt_x   = 18'($urandom_range(0, 131072) - 65536);
      ev.tilt_y   = 18'($urandom_range(0, 131072) - 65536);
    end
    return ev;
  endfunction

  task automatic push_event(input stroke_t ev);
    pending_events.push_back(ev);
    queued_total++;
  endtask

  task automatic push_corner_events();
    push_event(make_event(0, 0, 0, -65536, 65536));
    push_event(make_event(65535, 65536, 65536, 65536, -65536));
    push_event(make_event(16384, 131071, 131071, -131072, 131071));
    push_event(make_event(32768, 32768, 32768, 131071, -131072));
    push_event(make_event(49152, 1, 1, -1, 1));
    push_event(make_event(8192, 65535, 65535, 0, 0));
  endtask

  task automatic write_register(input mabis_cfg_t addr, input logic [12:0] value);
    longint prod;
    int     n;
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= addr;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (addr)
      CFG_DIMS:    cur_dims = value[2:0];
      CFG_BRUSHES: cur_brushes = value;
      CFG_MODES:   cur_modes = value[11:0];
      default:     cur_rank[int'(addr) - int'(CFG_RANK0)] = value;
    endcase
    n = (int'(cur_dims) > MAX_AXES) ? MAX_AXES : int'(cur_dims);
    prod = 1;
    for (int i = MAX_AXES - 1; i >= 0; i--) begin
      if (i >= n) begin
        stride_state[i] = 13'd1;
      end else begin
        stride_state[i] = prod[12:0];
        prod = prod * clip_count(cur_rank[i], RANK_CAP);
        if (prod > longint'(MAX_BRUSHES)) begin
          prod = longint'(MAX_BRUSHES);
        end
      end
    end
  endtask

  task automatic settle();
    do @(posedge clk);
    while (accepted_total != queued_total || expected_picks.size() != 0);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_picks.push_back(predict_pick(offered_event));
        accepted_total++;
      end
      if (!in_valid || in_ready) begin
        if (send_idle > 0) begin
          send_idle <= send_idle - 1;
          in_valid  <= 1'b0;
        end else if (pending_events.size() != 0) begin
          if (!steady && $urandom_range(0, 5) == 0) begin
            send_idle <= $urandom_range(0, 10);
            in_valid  <= 1'b0;
          end else begin
            offered_event = pending_events.pop_front();
            stroke_direction <= offered_event.direction;
            stroke_velocity  <= offered_event.velocity;
            pen_pressure     <= offered_event.pressure;
            tilt_x           <= offered_event.tilt_x;
            tilt_y           <= offered_event.tilt_y;
            in_valid         <= 1'b1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_picks.size() == 0) begin
          $error("unexpected result transfer: brush_index %0d, wants_null_motion %0b",
                 brush_index, wants_null_motion);
          mismatches++;
        end else begin
          oldest_pick = expected_picks.pop_front();
          if (brush_index !== oldest_pick.brush_index) begin
            $error("brush_index: expected %0d, actual %0d",
                   oldest_pick.brush_index, brush_index);
            mismatches++;
          end
          if (wants_null_motion !== oldest_pick.null_motion) begin
            $error("wants_null_motion: expected %0b, actual %0b",
                   oldest_pick.null_motion, wants_null_motion);
            mismatches++;
          end
        end
      end
      if (hold_off) begin
        out_ready <= 1'b0;
      end else if (recv_idle > 0) begin
        recv_idle <= recv_idle - 1;
        out_ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        recv_idle <= $urandom_range(0, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    wait (hold_request);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst              = 1'b1;
    cfg_valid        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_valid         = 1'b0;
    stroke_direction = '0;
    stroke_velocity  = '0;
    pen_pressure     = '0;
    tilt_x           = '0;
    tilt_y           = '0;
    out_ready        = 1'b0;
    cur_dims         = 3'd1;
    cur_brushes      = 13'd1;
    cur_modes        = 12'd1;
    lfsr_state       = LFSR_SEED;
    for (int i = 0; i < MAX_AXES; i++) begin
      cur_rank[i]     = 13'd1;
      idx_state[i]    = '0;
      stride_state[i] = 13'd1;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // A single brush answers zero and leaves the state alone.
    push_event(make_event(65535, 131071, 131071, 131071, -131072));
    push_event(make_event(0, 0, 0, 0, 0));
    settle();

    write_register(CFG_DIMS, 13'd4);
    write_register(CFG_BRUSHES, 13'd4096);
    write_register(CFG_MODES, {1'b0, MODE_XTILT, MODE_PRES, MODE_VEL, MODE_ANGLE});
    write_register(CFG_RANK0, 13'd8);
    write_register(CFG_RANK1, 13'd8);
    write_register(CFG_RANK2, 13'd8);
    write_register(CFG_RANK3, 13'd8);
    push_corner_events();
    settle();

    write_register(CFG_MODES, {1'b0, MODE_CONST, MODE_INCR, MODE_RANDOM, MODE_YTILT});
    push_corner_events();
    settle();

    // Stored indices above a lowered rank are clamped, or wrapped on the incremental axis, on the next event.
    write_register(CFG_RANK2, 13'd3);
    write_register(CFG_RANK3, 13'd2);
    push_event(make_event(1000, 2000, 3000, 4000, 5000));
    settle();

    write_register(CFG_DIMS, 13'd0);
    push_event(make_event(0, 65536, 65536, 65536, 65536));
    settle();

    write_register(CFG_DIMS, 13'd7);
    write_register(CFG_RANK0, 13'd0);
    write_register(CFG_RANK1, 13'd5000);
    write_register(CFG_BRUSHES, 13'd8191);
    push_event(make_event(12345, 54321, 100, -200, 300));
    push_event(make_event(40000, 0, 131071, 131071, -1));
    settle();

    write_register(CFG_BRUSHES, 13'd0);
    push_event(make_event(20000, 30000, 40000, 50000, -50000));
    settle();

    for (int phase = 0; phase < 12; phase++) begin
      steady = (phase == 11) || ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0:       write_register(CFG_DIMS, {10'($urandom), 3'd0});
        1:       write_register(CFG_DIMS, {10'($urandom), 3'($urandom_range(5, 7))});
        default: write_register(CFG_DIMS, {10'($urandom), 3'($urandom_range(1, 4))});
      endcase
      case ($urandom_range(0, 9))
        0:       write_register(CFG_BRUSHES, 13'd4096);
        1:       write_register(CFG_BRUSHES, 13'd1);
        2:       write_register(CFG_BRUSHES, 13'($urandom));
        default: write_register(CFG_BRUSHES, 13'($urandom_range(2, 400)));
      endcase
      write_register(CFG_MODES, 13'($urandom));
      for (int i = 0; i < MAX_AXES; i++) begin
        case ($urandom_range(0, 9))
          0:       write_register(mabis_cfg_t'(int'(CFG_RANK0) + i), 13'd4096);
          1:       write_register(mabis_cfg_t'(int'(CFG_RANK0) + i), 13'd0);
          2:       write_register(mabis_cfg_t'(int'(CFG_RANK0) + i), 13'($urandom));
          default: write_register(mabis_cfg_t'(int'(CFG_RANK0) + i),
                                  13'($urandom_range(1, 12)));
        endcase
      end
      repeat (90) push_event(random_event());
      if (phase == 2) begin
        hold_request = 1'b1;
      end
      settle();
    end

    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_picks.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
